// ===== sv/pes_pkg.sv =====
`default_nettype none

package pes_pkg;

    localparam int PIXEL_BITS      = 8;
    localparam int FIELD_BITS      = 12;
    localparam int THRESH_BITS     = 8;

    localparam int COORD_BITS_DEF  = 12;
    localparam int MAX_LEN_DEF     = 4096;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] value;
        logic [FIELD_BITS-1:0] x;
        logic [FIELD_BITS-1:0] y;
        logic                  last;
    } pixel_t;

    typedef struct packed {
        logic                  found;
        logic [FIELD_BITS-1:0] x;
        logic [FIELD_BITS-1:0] y;
        logic [FIELD_BITS-1:0] index;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/pes_in_stage.sv =====
`default_nettype none

module pes_in_stage
(
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_valid,
    output logic             in_ready,
    input  pes_pkg::pixel_t  in_pixel,
    input  wire              advance,
    output logic             stage_valid,
    output pes_pkg::pixel_t  stage_pixel
);

    logic            valid_reg;
    logic            valid_next;
    pes_pkg::pixel_t pixel_reg;

    // slot is free when empty or when its word moves on this cycle
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            pixel_reg <= in_pixel;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_pixel = pixel_reg;

endmodule

`default_nettype wire

// ===== sv/pes_search.sv =====
`default_nettype none

module pes_search
#(
    parameter int COORD_BITS      = pes_pkg::COORD_BITS_DEF,
    parameter int MAX_PROFILE_LEN = pes_pkg::MAX_LEN_DEF
)
(
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               step,
    input  pes_pkg::pixel_t                   pixel,
    input  wire [pes_pkg::THRESH_BITS-1:0]    threshold,
    output pes_pkg::result_t                  result
);

    localparam int STORE_BITS = (COORD_BITS < pes_pkg::FIELD_BITS) ?
                                COORD_BITS : pes_pkg::FIELD_BITS;
    localparam int CNT_BITS   = $clog2(MAX_PROFILE_LEN + 1);
    localparam int PB         = pes_pkg::PIXEL_BITS;
    localparam int FB         = pes_pkg::FIELD_BITS;

    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [PB-1:0]         pix0_reg, pix1_reg;
    logic [PB-1:0]         grad0_reg, grad1_reg;
    logic [STORE_BITS-1:0] cx_reg [3];
    logic [STORE_BITS-1:0] cy_reg [3];
    logic                  best_valid_reg, best_valid_next;
    logic [PB-1:0]         best_grad_reg, best_grad_next;
    logic [STORE_BITS-1:0] best_x_reg, best_x_next;
    logic [STORE_BITS-1:0] best_y_reg, best_y_next;
    logic [FB-1:0]         best_pos_reg, best_pos_next;

    logic                  active;
    logic                  judge;
    logic [PB-1:0]         grad_new;
    logic [STORE_BITS-1:0] x_in, y_in;

    assign active = count_reg < CNT_BITS'(MAX_PROFILE_LEN);
    assign x_in   = pixel.x[STORE_BITS-1:0];
    assign y_in   = pixel.y[STORE_BITS-1:0];

    // gradient of the position just behind the new pixel, clamped at zero
    always_comb
    begin
        grad_new = '0;
        if (count_reg >= CNT_BITS'(2) && pixel.value > pix1_reg)
        begin
            grad_new = pixel.value - pix1_reg;
        end
    end

    // position count-3 is now known to be eligible; first strict maximum wins
    assign judge = active && count_reg >= CNT_BITS'(4) && grad1_reg > threshold &&
                   (!best_valid_reg || grad1_reg > best_grad_reg);

    always_comb
    begin
        best_valid_next = best_valid_reg;
        best_grad_next  = best_grad_reg;
        best_x_next     = best_x_reg;
        best_y_next     = best_y_reg;
        best_pos_next   = best_pos_reg;
        if (judge)
        begin
            best_valid_next = 1'b1;
            best_grad_next  = grad1_reg;
            best_x_next     = cx_reg[2];
            best_y_next     = cy_reg[2];
            best_pos_next   = FB'(count_reg - CNT_BITS'(3));
        end
    end

    always_comb
    begin
        result.found = best_valid_next;
        result.x     = best_valid_next ? FB'(best_x_next) : '0;
        result.y     = best_valid_next ? FB'(best_y_next) : '0;
        result.index = best_valid_next ? best_pos_next : '0;
    end

    always_comb
    begin
        count_next = count_reg;
        if (active)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
        if (pixel.last)
        begin
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            best_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            count_reg      <= count_next;
            best_valid_reg <= best_valid_next && !pixel.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && active)
        begin
            grad1_reg <= grad0_reg;
            grad0_reg <= grad_new;
            pix1_reg  <= pix0_reg;
            pix0_reg  <= pixel.value;
            cx_reg[2] <= cx_reg[1];
            cx_reg[1] <= cx_reg[0];
            cx_reg[0] <= x_in;
            cy_reg[2] <= cy_reg[1];
            cy_reg[1] <= cy_reg[0];
            cy_reg[0] <= y_in;
        end
        if (step)
        begin
            best_grad_reg <= best_grad_next;
            best_x_reg    <= best_x_next;
            best_y_reg    <= best_y_next;
            best_pos_reg  <= best_pos_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/pes_out_stage.sv =====
`default_nettype none

module pes_out_stage
(
    input  wire               clk,
    input  wire               rst_n,
    input  wire               load,
    input  pes_pkg::result_t  load_result,
    output logic              free,
    output logic              out_valid,
    input  wire               out_ready,
    output pes_pkg::result_t  out_result
);

    logic             valid_reg;
    logic             valid_next;
    pes_pkg::result_t result_reg;

    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (out_ready)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= load_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

`default_nettype wire

// ===== sv/profile_edge_search.sv =====
// Edge search along one scan profile.
// Input channel (in_valid/in_ready): one pixel word per cycle when ready, with
// its value, image coordinates and last_pixel on the final pixel of the profile.
// Output channel (out_valid/out_ready): one word per profile, sent for the
// last pixel: edge_found and the coordinates and index of the first strongest
// gradient above the threshold, or all zero when no position qualifies.
// Config channel (cfg_valid/cfg_ready): writes gradient_threshold; always
// ready, write only while the block is idle.
// Path: a pixel is taken into the input register, and the result word is
// loaded into the output register as the last pixel leaves the input register.
// Throughput: one pixel per cycle while no last pixel waits for the output
// register; the input register feeds the gradient/compare logic.
// Stall: while the output register holds an untaken word, pixels keep
// flowing until a last pixel reaches the input register; it waits there and
// in_ready drops until out_ready frees the output register.
// Reset: clears the profile state, both handshake registers and sets the
// threshold to zero.
`default_nettype none

module profile_edge_search
#(
    parameter int COORD_BITS      = pes_pkg::COORD_BITS_DEF,
    parameter int MAX_PROFILE_LEN = pes_pkg::MAX_LEN_DEF
)
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire [pes_pkg::PIXEL_BITS-1:0]    pixel_value,
    input  wire [pes_pkg::FIELD_BITS-1:0]    pixel_x,
    input  wire [pes_pkg::FIELD_BITS-1:0]    pixel_y,
    input  wire                              last_pixel,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic                             edge_found,
    output logic [pes_pkg::FIELD_BITS-1:0]   edge_x,
    output logic [pes_pkg::FIELD_BITS-1:0]   edge_y,
    output logic [pes_pkg::FIELD_BITS-1:0]   edge_index,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire [pes_pkg::THRESH_BITS-1:0]   gradient_threshold
);

    logic [pes_pkg::THRESH_BITS-1:0] thresh_reg;
    pes_pkg::pixel_t                 in_pixel;
    pes_pkg::pixel_t                 stage_pixel;
    logic                            stage_valid;
    logic                            advance;
    logic                            step;
    logic                            out_free;
    pes_pkg::result_t                search_result;
    pes_pkg::result_t                out_result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= '0;
        end
        else if (cfg_valid)
        begin
            thresh_reg <= gradient_threshold;
        end
    end

    assign in_pixel.value = pixel_value;
    assign in_pixel.x     = pixel_x;
    assign in_pixel.y     = pixel_y;
    assign in_pixel.last  = last_pixel;

    // only a last pixel needs room in the output register
    assign advance = !stage_pixel.last || out_free;
    assign step    = stage_valid && advance;

    pes_in_stage u_in_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_pixel    (in_pixel),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_pixel (stage_pixel)
    );

    pes_search
    #(
        .COORD_BITS      (COORD_BITS),
        .MAX_PROFILE_LEN (MAX_PROFILE_LEN)
    )
    u_search
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .pixel     (stage_pixel),
        .threshold (thresh_reg),
        .result    (search_result)
    );

    pes_out_stage u_out_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (step && stage_pixel.last),
        .load_result (search_result),
        .free        (out_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_result  (out_result)
    );

    assign edge_found = out_result.found;
    assign edge_x     = out_result.x;
    assign edge_y     = out_result.y;
    assign edge_index = out_result.index;

endmodule

`default_nettype wire

// ===== bench/profile_edge_search_tb.sv =====
module profile_edge_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIXEL_BITS    = pes_pkg::PIXEL_BITS;
    localparam int FIELD_BITS    = pes_pkg::FIELD_BITS;
    localparam int THRESH_BITS   = pes_pkg::THRESH_BITS;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_PIXELS  = 190;
    // short profile limit keeps the overlong case small
    localparam int MAX_LEN       = 256;
    localparam int LONG_LEN      = MAX_LEN + 4;

    typedef pes_pkg::pixel_t  pixel_t;
    typedef pes_pkg::result_t result_t;

    typedef logic [PIXEL_BITS-1:0] value_q_t [$];

    typedef enum int {COORD_WALK, COORD_CORNERS, COORD_SCATTER} coord_style_t;
    typedef enum int {SHAPE_NOISE, SHAPE_STEP, SHAPE_STAIRS, SHAPE_FLAT} profile_shape_t;
    typedef enum int {READY_ALWAYS, READY_RANDOM, READY_HELD_OFF} ready_mode_t;

    class edge_scoreboard;
        logic [THRESH_BITS-1:0]    threshold;
        logic [PIXEL_BITS-1:0]     pixel_hist [3];
        logic [2*FIELD_BITS-1:0]   coord_hist [3];
        logic [PIXEL_BITS-1:0]     grad_hist [2];
        logic [FIELD_BITS:0]       taken;
        logic [PIXEL_BITS-1:0]     peak_grad;
        logic [2*FIELD_BITS-1:0]   peak_coords;
        logic [FIELD_BITS-1:0]     peak_pos;
        logic                      peak_valid;
        result_t                   expected_edges [$];
        int                        errors;

        function new();
            threshold = '0;
            errors = 0;
            restart_profile();
        endfunction

        function void restart_profile();
            for (int i = 0; i < 3; i++) begin
                pixel_hist[i] = '0;
                coord_hist[i] = '0;
            end
            grad_hist[0] = '0;
            grad_hist[1] = '0;
            taken = '0;
            peak_grad = '0;
            peak_coords = '0;
            peak_pos = '0;
            peak_valid = 1'b0;
        endfunction

        function void note_pixel(pixel_t p);
            logic [PIXEL_BITS-1:0] rise;
            result_t r;
            // search stops once the profile is full; last still closes it
            if (taken < MAX_LEN) begin
                rise = '0;
                if (taken >= 2 && p.value > pixel_hist[1])
                    rise = p.value - pixel_hist[1];
                // position taken-3 is now known to be eligible
                if (taken >= 4 && grad_hist[1] > threshold &&
                    (!peak_valid || grad_hist[1] > peak_grad)) begin
                    peak_grad = grad_hist[1];
                    peak_coords = coord_hist[2];
                    peak_pos = FIELD_BITS'(taken - 3);
                    peak_valid = 1'b1;
                end
                grad_hist[1] = grad_hist[0];
                grad_hist[0] = rise;
                pixel_hist[2] = pixel_hist[1];
                pixel_hist[1] = pixel_hist[0];
                pixel_hist[0] = p.value;
                coord_hist[2] = coord_hist[1];
                coord_hist[1] = coord_hist[0];
                coord_hist[0] = {p.y, p.x};
                taken = taken + 1;
            end
            if (p.last) begin
                r = '0;
                if (peak_valid) begin
                    r.found = 1'b1;
                    r.x = peak_coords[FIELD_BITS-1:0];
                    r.y = peak_coords[2*FIELD_BITS-1:FIELD_BITS];
                    r.index = peak_pos;
                end
                expected_edges.insert(expected_edges.size(), r);
                restart_profile();
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_edges.size() == 0) begin
                $error("unexpected result word: found %0d x %0d y %0d index %0d",
                       got.found, got.x, got.y, got.index);
                errors++;
                return;
            end
            want = expected_edges.pop_front();
            compare_field("edge_found", want.found, got.found);
            compare_field("edge_x", want.x, got.x);
            compare_field("edge_y", want.y, got.y);
            compare_field("edge_index", want.index, got.index);
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic [PIXEL_BITS-1:0]   pixel_value;
    logic [FIELD_BITS-1:0]   pixel_x;
    logic [FIELD_BITS-1:0]   pixel_y;
    logic                    last_pixel;
    logic                    out_valid;
    logic                    out_ready;
    logic                    edge_found;
    logic [FIELD_BITS-1:0]   edge_x;
    logic [FIELD_BITS-1:0]   edge_y;
    logic [FIELD_BITS-1:0]   edge_index;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [THRESH_BITS-1:0]  gradient_threshold;

    edge_scoreboard sb = new();

    int unsigned cycle_count = 0;
    int          burst_left = 0;
    int          stall_left = 0;
    ready_mode_t ready_mode = READY_ALWAYS;

    profile_edge_search
    #(
        .MAX_PROFILE_LEN (MAX_LEN)
    )
    i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .pixel_value        (pixel_value),
        .pixel_x            (pixel_x),
        .pixel_y            (pixel_y),
        .last_pixel         (last_pixel),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .edge_found         (edge_found),
        .edge_x             (edge_x),
        .edge_y             (edge_y),
        .edge_index         (edge_index),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .gradient_threshold (gradient_threshold)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.threshold = gradient_threshold;
            if (in_valid && in_ready)
                sb.note_pixel('{value: pixel_value, x: pixel_x, y: pixel_y,
                                last: last_pixel});
            if (out_valid && out_ready)
                sb.check_result('{found: edge_found, x: edge_x, y: edge_y,
                                  index: edge_index});
        end
    end

    // receiver: runs of always-ready, coin-flip ready and held off
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            ready_mode = ready_mode_t'($urandom_range(0, 2));
            stall_left = (ready_mode == READY_HELD_OFF) ? $urandom_range(1, 12)
                                                       : $urandom_range(1, 40);
        end
        else
            stall_left--;
        case (ready_mode)
            READY_ALWAYS: out_ready <= 1'b1;
            READY_RANDOM: out_ready <= 1'($urandom_range(0, 1));
            default:      out_ready <= 1'b0;
        endcase
    end

    task pace();
        int gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                gap = 0;
                burst_left = $urandom_range(30, 80);
            end
            else
            begin
                gap = $urandom_range(0, 6);
                burst_left = $urandom_range(1, 16);
            end
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        burst_left--;
    endtask

    task send_pixel(pixel_t p);
        pace();
        @(negedge clk);
        in_valid    <= 1'b1;
        pixel_value <= p.value;
        pixel_x     <= p.x;
        pixel_y     <= p.y;
        last_pixel  <= p.last;
        do @(posedge clk); while (!in_ready);
    endtask

    task send_profile(input value_q_t vals, input coord_style_t style);
        pixel_t                p;
        logic [FIELD_BITS-1:0] cx;
        logic [FIELD_BITS-1:0] cy;
        int                    dx;
        int                    dy;
        cx = FIELD_BITS'($urandom_range(0, 4095));
        cy = FIELD_BITS'($urandom_range(0, 4095));
        dx = int'($urandom_range(0, 2)) - 1;
        dy = int'($urandom_range(0, 2)) - 1;
        foreach (vals[i])
        begin
            case (style)
                COORD_WALK:
                begin
                    p.x = cx;
                    p.y = cy;
                    cx = cx + FIELD_BITS'(dx);
                    cy = cy + FIELD_BITS'(dy);
                end
                COORD_CORNERS:
                begin
                    p.x = (i % 2 == 1) ? '1 : '0;
                    p.y = (i % 2 == 1) ? '0 : '1;
                end
                default:
                begin
                    p.x = FIELD_BITS'($urandom_range(0, 4095));
                    p.y = FIELD_BITS'($urandom_range(0, 4095));
                end
            endcase
            p.value = vals[i];
            p.last = (i == vals.size() - 1);
            send_pixel(p);
        end
    endtask

    function automatic value_q_t make_profile(int len, int thr);
        value_q_t       vals;
        profile_shape_t shape;
        int             lo;
        int             hi;
        int             pos;
        int             noise;
        int             rise;
        int             v;
        shape = profile_shape_t'($urandom_range(0, 3));
        lo = $urandom_range(0, 255);
        // bias step heights onto the threshold boundary
        if ($urandom_range(0, 2) == 0)
            hi = lo + thr + int'($urandom_range(0, 2)) - 1;
        else
            hi = $urandom_range(0, 255);
        if (hi > 255)
            hi = 255;
        if (hi < 0)
            hi = 0;
        pos = $urandom_range(0, len);
        noise = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 4);
        rise = $urandom_range(1, 40);
        for (int i = 0; i < len; i++)
        begin
            case (shape)
                SHAPE_NOISE:  v = $urandom_range(0, 255);
                SHAPE_STEP:   v = (i < pos) ? lo : hi;
                SHAPE_STAIRS: v = lo + (i / 2) * rise;
                default:      v = lo;
            endcase
            v = v + int'($urandom_range(0, noise));
            if (v > 255)
                v = 255;
            vals.insert(vals.size(), PIXEL_BITS'(v));
        end
        return vals;
    endfunction

    // block is idle once every result is back and the pipe has drained
    task settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_edges.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task write_threshold(logic [THRESH_BITS-1:0] thr);
        settle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        gradient_threshold <= thr;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task run_phase(logic [THRESH_BITS-1:0] thr, int pixels);
        int sent;
        int len;
        write_threshold(thr);
        sent = 0;
        while (sent < pixels)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(31, 200)
                                             : $urandom_range(1, 30);
            send_profile(make_profile(len, thr), coord_style_t'($urandom_range(0, 2)));
            sent += len;
        end
    endtask

    initial
    begin
        value_q_t long_vals;
        rst_n = 1'b0;
        in_valid = 1'b0;
        pixel_value = '0;
        pixel_x = '0;
        pixel_y = '0;
        last_pixel = 1'b0;
        cfg_valid = 1'b0;
        gradient_threshold = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_threshold(8'd0);
        // single-pixel and short profiles never qualify
        send_profile('{8'd77}, COORD_WALK);
        send_profile('{8'd0, 8'd255, 8'd0, 8'd255}, COORD_SCATTER);
        // shortest profile with an eligible position, full-scale gradient
        send_profile('{8'd0, 8'd0, 8'd255, 8'd255, 8'd255}, COORD_CORNERS);
        // equal gradients: the first one wins
        send_profile('{8'd0, 8'd10, 8'd10, 8'd20, 8'd20, 8'd30, 8'd30}, COORD_WALK);
        // falling slope clamps to zero, not above threshold 0
        send_profile('{8'd255, 8'd128, 8'd0, 8'd0, 8'd0}, COORD_CORNERS);

        run_phase(8'd0, PHASE_PIXELS);
        run_phase(8'd255, PHASE_PIXELS);
        run_phase(8'd1, PHASE_PIXELS);
        run_phase(8'd128, PHASE_PIXELS);
        run_phase(8'd254, PHASE_PIXELS);
        repeat (3)
            run_phase(THRESH_BITS'($urandom_range(0, 255)), PHASE_PIXELS);

        // overlong profile: edge at the last eligible position, then a
        // strong step among the pixels the search ignores
        for (int i = 0; i < LONG_LEN; i++)
        begin
            if (i < MAX_LEN - 3)
                long_vals.insert(long_vals.size(), 8'd50);
            else if (i < MAX_LEN)
                long_vals.insert(long_vals.size(), 8'd200);
            else
                long_vals.insert(long_vals.size(), (i % 2 == 1) ? 8'd255 : 8'd0);
        end
        write_threshold(8'd0);
        send_profile(long_vals, COORD_WALK);

        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_edges.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
